// ----- rtl/assert_macros.svh -----
// Shared assertion wrappers, sampled on clk and silent while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/slr_pkg.sv -----
`default_nettype none

package slr_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int PHASE_FRAC_BITS   = 16;
    localparam int PHASE_W           = 18;
    localparam int ACC_W             = PHASE_W + 1;
    localparam int COUNT_W           = 16;
    localparam int MAX_OUT_PER_FRAME = 64;
    localparam int N_W               = $clog2(MAX_OUT_PER_FRAME + 1);
    localparam int DIFF_W            = SAMPLE_W + 1;
    localparam int PROD_W            = DIFF_W + PHASE_FRAC_BITS + 1;
    localparam int NUM_W             = PROD_W + 1;
    localparam int TDATA_W           = 2 * SAMPLE_W;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = PHASE_W;

    localparam logic [PHASE_W-1:0] STEP_RATIO_RESET = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [COUNT_W-1:0] FRAMES_RESET     = COUNT_W'(1024);
    localparam logic [ACC_W-1:0]   PHASE_ONE        = ACC_W'(1) << PHASE_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RATIO = 1'b0,
        REG_FRAMES     = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/stereo_linear_resampler_core.sv -----
// After a source frame transaction the gate, loop and multiply steps come before the emit
//   step loads the first output frame. No new source frame is taken until the current one
//   leaves the 3-step microcode loop around the multiplier and is stored (or is only stored).
// Output register decouples the sides: a stalled output only holds the emit step.
// Reset (rst_n, async, active low): step_ratio=1.0, frames_to_emit=1024, history and
//   phase cleared, no output pending.
`default_nettype none

module stereo_linear_resampler_core
    import slr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // source frames
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,   // [15:0] left_in, [31:16] right_in
    input  wire logic                  s_tuser,   // [0] block_start
    // resampled frames
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [TDATA_W-1:0]    m_tdata,   // [15:0] left_out, [31:16] right_out
    output      logic                  m_tlast,   // last_frame
    // register writes
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Microcode: step names, branch kinds and the control word.
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,   // wait for a source frame
        ST_GATE  = 3'd1,   // skip interpolation if no history or block finished
        ST_LOOP  = 3'd2,   // loop test: phase < 1, cap, count, not done
        ST_MUL   = 3'd3,   // (cur - prev) * frac into product registers
        ST_EMIT  = 3'd4,   // finish lerp, load output, advance phase/count
        ST_FIX   = 3'd5,   // wrap phase past one, or zero it
        ST_STORE = 3'd6    // current frame becomes history
    } step_t;

    typedef enum logic [2:0] {
        BR_NEXT,   // step + 1
        BR_GOTO,   // target
        BR_IN,     // hold until a source transaction, then step + 1
        BR_SKIP,   // target if interpolation is skipped, else step + 1
        BR_EXIT,   // target when the loop test fails, else step + 1
        BR_OUT     // hold while the output register is full and stalled, then target
    } br_t;

    typedef struct packed {
        br_t   br;
        step_t target;
        logic  ld_in;
        logic  mul;
        logic  emit;
        logic  fix;
        logic  store;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        begin
            w = '{br: BR_GOTO, target: ST_IDLE, default: 1'b0};
            unique case (s)
                ST_IDLE:  begin w.br = BR_IN;   w.ld_in = 1'b1; end
                ST_GATE:  begin w.br = BR_SKIP; w.target = ST_STORE; end
                ST_LOOP:  begin w.br = BR_EXIT; w.target = ST_FIX; end
                ST_MUL:   begin w.br = BR_NEXT; w.mul = 1'b1; end
                ST_EMIT:  begin w.br = BR_OUT;  w.target = ST_LOOP; w.emit = 1'b1; end
                ST_FIX:   begin w.br = BR_NEXT; w.fix = 1'b1; end
                ST_STORE: begin w.br = BR_GOTO; w.target = ST_IDLE; w.store = 1'b1; end
                default:  begin w.br = BR_GOTO; w.target = ST_IDLE; end
            endcase
            return w;
        end
    endfunction

    localparam logic signed [NUM_W-1:0] TRUNC_BIAS = (NUM_W'(1) << PHASE_FRAC_BITS) - NUM_W'(1);

    // prev*ONE + product, truncated toward zero, back to sample width
    function automatic logic signed [SAMPLE_W-1:0] lerp_fin(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [PROD_W-1:0]   p
    );
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] adj;
        logic signed [NUM_W-1:0] q;
        begin
            num = (NUM_W'(a) <<< PHASE_FRAC_BITS) + NUM_W'(p);
            adj = num + (num[NUM_W-1] ? TRUNC_BIAS : '0);
            q   = adj >>> PHASE_FRAC_BITS;
            return q[SAMPLE_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    step_t                        step_reg,    step_next;
    logic [PHASE_W-1:0]           ratio_reg,   ratio_next;
    logic [COUNT_W-1:0]           frames_reg,  frames_next;
    logic signed [SAMPLE_W-1:0]   prev_l_reg,  prev_l_next;
    logic signed [SAMPLE_W-1:0]   prev_r_reg,  prev_r_next;
    logic signed [SAMPLE_W-1:0]   cur_l_reg,   cur_l_next;
    logic signed [SAMPLE_W-1:0]   cur_r_reg,   cur_r_next;
    logic                         have_reg,    have_next;
    logic [PHASE_W-1:0]           phase_reg,   phase_next;
    logic [ACC_W-1:0]             ph_reg,      ph_next;      // working phase
    logic [COUNT_W-1:0]           emitted_reg, emitted_next;
    logic                         done_reg,    done_next;
    logic [N_W-1:0]               n_reg,       n_next;       // outputs for this frame
    logic signed [PROD_W-1:0]     prod_l_reg,  prod_l_next;
    logic signed [PROD_W-1:0]     prod_r_reg,  prod_r_next;
    logic                         ovalid_reg,  ovalid_next;
    logic signed [SAMPLE_W-1:0]   out_l_reg,   out_l_next;
    logic signed [SAMPLE_W-1:0]   out_r_reg,   out_r_next;
    logic                         olast_reg,   olast_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    ucode_t                         uw;
    logic                           in_fire;
    logic                           stall;
    logic                           below_one;
    logic                           loop_ok;
    logic                           skip;
    logic signed [DIFF_W-1:0]       diff_l;
    logic signed [DIFF_W-1:0]       diff_r;
    logic signed [PHASE_FRAC_BITS:0] frac_s;
    logic [COUNT_W-1:0]             cnt_inc;

    assign uw        = ucode_rom(step_reg);
    assign s_tready  = (step_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign stall     = uw.emit && ovalid_reg && !m_tready;
    assign below_one = (ph_reg[ACC_W-1:PHASE_FRAC_BITS] == '0);
    assign loop_ok   = !done_reg && below_one && (n_reg < N_W'(MAX_OUT_PER_FRAME))
                       && (emitted_reg < frames_reg);
    assign skip      = !have_reg || done_reg;
    assign diff_l    = DIFF_W'(cur_l_reg) - DIFF_W'(prev_l_reg);
    assign diff_r    = DIFF_W'(cur_r_reg) - DIFF_W'(prev_r_reg);
    assign frac_s    = {1'b0, ph_reg[PHASE_FRAC_BITS-1:0]};
    assign cnt_inc   = emitted_reg + COUNT_W'(1);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {out_r_reg, out_l_reg};
    assign m_tlast   = olast_reg;

    always_comb
    begin
        step_next    = step_reg;
        ratio_next   = ratio_reg;
        frames_next  = frames_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        cur_l_next   = cur_l_reg;
        cur_r_next   = cur_r_reg;
        have_next    = have_reg;
        phase_next   = phase_reg;
        ph_next      = ph_reg;
        emitted_next = emitted_reg;
        done_next    = done_reg;
        n_next       = n_reg;
        prod_l_next  = prod_l_reg;
        prod_r_next  = prod_r_reg;
        ovalid_next  = ovalid_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        olast_next   = olast_reg;

        // output register drains on its handshake
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        // register writes; the user must make them only while idle, the block does not check
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_RATIO: ratio_next  = cfg_data;
                REG_FRAMES:     frames_next = cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end

        // sequencer
        case (uw.br)
            BR_NEXT: step_next = step_t'(step_reg + 3'd1);
            BR_GOTO: step_next = uw.target;
            BR_IN:   step_next = in_fire ? step_t'(step_reg + 3'd1) : step_reg;
            BR_SKIP: step_next = skip ? uw.target : step_t'(step_reg + 3'd1);
            BR_EXIT: step_next = loop_ok ? step_t'(step_reg + 3'd1) : uw.target;
            BR_OUT:  step_next = stall ? step_reg : uw.target;
            default: step_next = ST_IDLE;
        endcase

        // microcode operations
        if (uw.ld_in && in_fire)
        begin
            cur_l_next = s_tdata[SAMPLE_W-1:0];
            cur_r_next = s_tdata[TDATA_W-1:SAMPLE_W];
            n_next     = '0;
            if (s_tuser)
            begin
                phase_next   = '0;
                ph_next      = '0;
                emitted_next = '0;
                done_next    = 1'b0;
                have_next    = 1'b0;
            end
            else
            begin
                ph_next = ACC_W'(phase_reg);
            end
        end

        if (uw.mul)
        begin
            prod_l_next = diff_l * frac_s;
            prod_r_next = diff_r * frac_s;
        end

        if (uw.emit && !stall)
        begin
            ovalid_next  = 1'b1;
            out_l_next   = lerp_fin(prev_l_reg, prod_l_reg);
            out_r_next   = lerp_fin(prev_r_reg, prod_r_reg);
            olast_next   = (cnt_inc >= frames_reg);
            done_next    = done_reg || (cnt_inc >= frames_reg);
            emitted_next = cnt_inc;
            n_next       = n_reg + N_W'(1);
            ph_next      = ph_reg + ACC_W'(ratio_reg);
        end

        if (uw.fix)
        begin
            phase_next = below_one ? '0 : PHASE_W'(ph_reg - PHASE_ONE);
        end

        if (uw.store)
        begin
            prev_l_next = cur_l_reg;
            prev_r_next = cur_r_reg;
            have_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            ratio_reg   <= STEP_RATIO_RESET;
            frames_reg  <= FRAMES_RESET;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            cur_l_reg   <= '0;
            cur_r_reg   <= '0;
            have_reg    <= 1'b0;
            phase_reg   <= '0;
            ph_reg      <= '0;
            emitted_reg <= '0;
            done_reg    <= 1'b0;
            n_reg       <= '0;
            prod_l_reg  <= '0;
            prod_r_reg  <= '0;
            ovalid_reg  <= 1'b0;
            out_l_reg   <= '0;
            out_r_reg   <= '0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            ratio_reg   <= ratio_next;
            frames_reg  <= frames_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            cur_l_reg   <= cur_l_next;
            cur_r_reg   <= cur_r_next;
            have_reg    <= have_next;
            phase_reg   <= phase_next;
            ph_reg      <= ph_next;
            emitted_reg <= emitted_next;
            done_reg    <= done_next;
            n_reg       <= n_next;
            prod_l_reg  <= prod_l_next;
            prod_r_reg  <= prod_r_next;
            ovalid_reg  <= ovalid_next;
            out_l_reg   <= out_l_next;
            out_r_reg   <= out_r_next;
            olast_reg   <= olast_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/slr_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module slr_checker
    import slr_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [TDATA_W-1:0]    m_tdata,
    input wire logic                  m_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // a source frame is worked on alone
    `ASSERT_NEXT(a_in_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // a new output frame only appears while a source frame is in work
    `ASSERT_IMPL(a_emit_while_busy, $rose(m_tvalid), !s_tready)

    // register writes are never back-pressured
    `ASSERT_IMPL(a_cfg_always_ready, cfg_valid, cfg_ready)

    // a stalled output frame holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind stereo_linear_resampler_core slr_checker u_slr_checker (.*);

`default_nettype wire

// ----- bench/stereo_linear_resampler_core_tb.sv -----
module stereo_linear_resampler_core_tb;
    import slr_pkg::*;

    // Rough drain time of one source frame with no output plus the delay to the first
    // output frame, with margin.
    localparam int SETTLE_CYCLES = 16;
    // Output side hold-off used to back up the pipeline.
    localparam int HOLD_CYCLES   = 400;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    localparam int TARGET_FRAMES = 370;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } out_frame_t;

    // Tracks phase, history and block count of the resampler and keeps the
    // output frames still owed by the DUT.
    class resample_scoreboard;
        logic [PHASE_W-1:0]         step_ratio;
        logic [COUNT_W-1:0]         frame_limit;
        logic signed [SAMPLE_W-1:0] prev_left;
        logic signed [SAMPLE_W-1:0] prev_right;
        bit                         have_prev;
        logic [PHASE_W-1:0]         phase;
        logic [COUNT_W-1:0]         emitted;
        bit                         block_done;
        out_frame_t                 expected_frames[$];
        int                         mismatches;

        function new();
            step_ratio  = STEP_RATIO_RESET;
            frame_limit = FRAMES_RESET;
            prev_left   = '0;
            prev_right  = '0;
            have_prev   = 1'b0;
            phase       = '0;
            emitted     = '0;
            block_done  = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_STEP_RATIO)
                step_ratio = value[PHASE_W-1:0];
            else
                frame_limit = value[COUNT_W-1:0];
        endfunction

        // a + (b - a) * frac, exact, then truncated toward zero
        function logic signed [SAMPLE_W-1:0] interp(logic signed [SAMPLE_W-1:0] a,
                                                    logic signed [SAMPLE_W-1:0] b,
                                                    logic [ACC_W-1:0] frac);
            longint num;
            longint q;
            num = longint'(a) * (longint'(1) << PHASE_FRAC_BITS)
                + (longint'(b) - longint'(a)) * longint'(frac);
            if (num < 0)
                q = -((-num) >>> PHASE_FRAC_BITS);
            else
                q = num >>> PHASE_FRAC_BITS;
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_source_frame(logic signed [SAMPLE_W-1:0] cur_left,
                                        logic signed [SAMPLE_W-1:0] cur_right,
                                        bit start);
            logic [ACC_W-1:0] ph;
            int               n;
            out_frame_t       f;
            n = 0;
            if (start) begin
                phase      = '0;
                emitted    = '0;
                block_done = 1'b0;
                have_prev  = 1'b0;
            end
            if (have_prev && !block_done) begin
                ph = ACC_W'(phase);
                while (ph < PHASE_ONE && n < MAX_OUT_PER_FRAME && emitted < frame_limit) begin
                    f.left  = interp(prev_left, cur_left, ph);
                    f.right = interp(prev_right, cur_right, ph);
                    f.last  = 1'b0;
                    emitted = emitted + 1'b1;
                    if (emitted >= frame_limit) begin
                        f.last     = 1'b1;
                        block_done = 1'b1;
                    end
                    expected_frames.push_back(f);
                    n++;
                    ph = ph + step_ratio;
                    if (block_done)
                        break;
                end
                // per-frame cap with phase still below one: restart at zero
                phase = (ph >= PHASE_ONE) ? PHASE_W'(ph - PHASE_ONE) : '0;
            end
            prev_left  = cur_left;
            prev_right = cur_right;
            have_prev  = 1'b1;
        endfunction

        function void check_output_frame(logic signed [SAMPLE_W-1:0] left,
                                         logic signed [SAMPLE_W-1:0] right,
                                         logic last);
            out_frame_t exp_f;
            if (expected_frames.size() == 0) begin
                $error("unexpected output frame: left_out %0d right_out %0d last_frame %0b",
                       left, right, last);
                mismatches++;
                return;
            end
            exp_f = expected_frames.pop_front();
            if (left !== exp_f.left) begin
                $error("left_out: expected %0d, got %0d", exp_f.left, left);
                mismatches++;
            end
            if (right !== exp_f.right) begin
                $error("right_out: expected %0d, got %0d", exp_f.right, right);
                mismatches++;
            end
            if (last !== exp_f.last) begin
                $error("last_frame: expected %0b, got %0b", exp_f.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;   // [15:0] left_in, [31:16] right_in
    logic                  s_tuser   = 1'b0; // [0] block_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;          // [15:0] left_out, [31:16] right_out
    logic                  m_tlast;          // last_frame
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_STEP_RATIO;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    resample_scoreboard sb = new();

    bit fast_mode   = 1'b0;  // both sides run without idling while set
    int hold_asks   = 0;     // bumped by the stimulus to ask for one long hold-off
    int frames_sent = 0;

    stereo_linear_resampler_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Drivers. All called at a rising edge; they return at the edge of the
    // transaction with valid still high so back-to-back items never toggle it.
    // ------------------------------------------------------------------
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right,
                              input bit start);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_source_frame(left, right, start);
        frames_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Stop the source and wait for every owed output frame; with settle set,
    // also let a frame that produces nothing run through.
    task automatic drain(input bit settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_frames.size() != 0) @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only legal with the block idle. Upper data bits of the frame count
    // register are junk on purpose.
    task automatic apply_settings(input logic [PHASE_W-1:0] step,
                                  input logic [COUNT_W-1:0] frames);
        drain(1'b1);
        write_reg(REG_STEP_RATIO, step);
        write_reg(REG_FRAMES,
                  CFG_DATA_W'(frames) | (CFG_DATA_W'($urandom_range(0, 3)) << COUNT_W));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall per frame, plus the long hold-off on request.
    // ------------------------------------------------------------------
    int stall     = 0;
    int hold_left = 0;
    int hold_seen = 0;

    initial
    begin
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                sb.check_output_frame(m_tdata[SAMPLE_W-1:0], m_tdata[TDATA_W-1:SAMPLE_W],
                                      m_tlast);
                stall = fast_mode ? 0 : $urandom_range(0, 15);
            end
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any channel counts as progress.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    initial
    begin
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stereo_linear_resampler_core_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int                 phase_no;
    int                 burst_len;
    int                 sel;
    logic [PHASE_W-1:0] step_pick;
    logic [COUNT_W-1:0] count_pick;
    bit                 start;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (ratio 1.0, 1024 frames). First frame has no history.
        send_frame(16'sd100, -16'sd100, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(-16'sd1, 16'sd1, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b1);           // block start: store only
        send_frame(16'sd12345, -16'sd12345, 1'b0);

        // Smallest legal ratio, short block: last flag, then frames after done.
        apply_settings(PHASE_W'(1024), COUNT_W'(5));
        send_frame(16'sh8000, 16'sh7fff, 1'b1);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sd5, 16'sd5, 1'b0);

        // Largest ratio, longest block: most source frames give nothing, and a
        // phase just under one exercises truncation toward zero.
        apply_settings(PHASE_W'(262143), COUNT_W'(65535));
        send_frame(16'sd1000, -16'sd1000, 1'b1);
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sh7fff, 16'sh7fff, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 1'b0);

        // Zero ratio: the per-frame cap bounds the burst and resets the phase.
        apply_settings(PHASE_W'(0), COUNT_W'(70));
        send_frame(16'sd7, -16'sd7, 1'b1);
        send_frame(16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd1, 16'sd1, 1'b0);

        // Zero frames per block: nothing comes out.
        apply_settings(PHASE_W'(65536), COUNT_W'(0));
        send_frame(16'sd1, 16'sd2, 1'b1);
        send_frame(16'sd3, 16'sd4, 1'b0);

        // Frame count lowered below the running count mid-block: output stops
        // with no flagged last frame.
        apply_settings(PHASE_W'(40000), COUNT_W'(100));
        send_frame(16'sd0, 16'sd0, 1'b1);
        send_frame(16'sd30000, -16'sd30000, 1'b0);
        send_frame(-16'sd30000, 16'sd30000, 1'b0);
        drain(1'b1);
        write_reg(REG_FRAMES, CFG_DATA_W'(2));
        cfg_valid <= 1'b0;
        send_frame(16'sd5, -16'sd5, 1'b0);

        // Random phases: mostly blocks opened by a block start with random
        // samples, some continuing across a settings change.
        phase_no = 0;
        while (frames_sent < TARGET_FRAMES) begin
            if (phase_no == 0) begin
                step_pick  = PHASE_W'(65536);
                count_pick = COUNT_W'(65535);
            end
            else begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: begin
                        step_pick  = PHASE_W'(1024);
                        count_pick = COUNT_W'($urandom_range(1, 200));
                    end
                    1: begin
                        step_pick  = PHASE_W'(262143);
                        count_pick = COUNT_W'(65535);
                    end
                    2: begin
                        step_pick  = PHASE_W'(65536);
                        count_pick = COUNT_W'($urandom_range(1, 60));
                    end
                    3: begin
                        step_pick  = PHASE_W'($urandom_range(32768, 131072));
                        count_pick = COUNT_W'($urandom_range(20, 300));
                    end
                    4: begin
                        step_pick  = PHASE_W'($urandom_range(1024, 262143));
                        count_pick = COUNT_W'(65535);
                    end
                    default: begin
                        // below the legal ratio range
                        step_pick  = PHASE_W'($urandom_range(0, 1023));
                        count_pick = COUNT_W'($urandom_range(1, 80));
                    end
                endcase
            end
            apply_settings(step_pick, count_pick);

            // first phase: no idling, output held off so the block backs up
            fast_mode = (phase_no == 0) || ($urandom_range(0, 3) == 0);
            if (phase_no == 0)
                hold_asks++;

            burst_len = $urandom_range(30, 45);
            for (int k = 0; k < burst_len; k++) begin
                if (phase_no == 2 && k == burst_len / 2)
                    drain(1'b0);
                start = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
                send_frame(draw_sample(), draw_sample(), start);
            end
            phase_no++;
        end

        drain(1'b1);
        if (sb.expected_frames.size() != 0) begin
            $error("%0d expected output frames never arrived", sb.expected_frames.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("stereo_linear_resampler_core_tb: done, clean");
        else
            $display("stereo_linear_resampler_core_tb: done, errors");
        $finish;
    end

endmodule
